// File: rtl/ffs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffs_pkg
// Shared types and constants of the flipbook frame sequencer.
// ----------------------------------------------------------------------------
package ffs_pkg;

  localparam int unsigned FRAME_BITS = 8;
  localparam int unsigned TIME_W     = 24;
  localparam int unsigned DT_W       = 16;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned SPEED_FRAC = 12;
  localparam int unsigned PROD_W     = DT_W + SPEED_W;
  localparam int unsigned SCL_W      = PROD_W - SPEED_FRAC;
  localparam int unsigned T_W        = TIME_W + 2;
  localparam int unsigned LOOP_W     = 8;

  localparam int unsigned APB_DW     = 32;
  localparam int unsigned REG_NUM    = 8;
  localparam int unsigned REG_IDX_W  = $clog2(REG_NUM);
  localparam int unsigned APB_AW     = REG_IDX_W + 2;

  localparam logic [FRAME_BITS-1:0] FRAME_COUNT_RST    = FRAME_BITS'(2);
  localparam logic [TIME_W-1:0]     FRAME_DURATION_RST = TIME_W'(1);
  localparam logic [SPEED_W-1:0]    SPEED_RST          = SPEED_W'(4096);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_COUNT    = 3'd0,
    REG_FRAME_DURATION = 3'd1,
    REG_SPEED          = 3'd2,
    REG_LOOP_FOREVER   = 3'd3,
    REG_PING_PONG      = 3'd4,
    REG_LOOP_BUDGET    = 3'd5,
    REG_START_BACKWARD = 3'd6,
    REG_START_FRAME    = 3'd7
  } ffs_reg_e;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

endpackage

// File: rtl/flipbook_frame_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flipbook_frame_sequencer
// Sprite animation frame sequencer for one player, with APB register port.
// ----------------------------------------------------------------------------
// Flow: a start item, or a tick while stopped, gives its result in the cycle
//   after acceptance; a running tick goes through ST_MUL and ST_SUB, then one
//   ST_STEP per frame step (each adds one frame duration in the shared adder).
// Throughput: one item at a time; the next is taken the cycle after the
//   result item is accepted.
// Reset: asynchronous, active low; stopped, frame 0, registers at defaults.
module flipbook_frame_sequencer
  import ffs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [DT_W-1:0]       dt_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [FRAME_BITS-1:0] frame_index_o,
  output logic                  backward_o,
  output logic                  stopped_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_STEP,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [FRAME_BITS-1:0] frame_count_q;
  logic [TIME_W-1:0]     frame_duration_q;
  logic [SPEED_W-1:0]    speed_q;
  logic                  loop_forever_q;
  logic                  ping_pong_q;
  logic [LOOP_W-1:0]     loop_budget_q;
  logic                  start_backward_q;
  logic [FRAME_BITS-1:0] start_frame_q;

  logic [FRAME_BITS-1:0] frame_pos_q;
  logic                  dir_q;
  logic [LOOP_W-1:0]     loops_left_q;
  logic [TIME_W-1:0]     time_left_q;
  logic                  ended_q;
  logic signed [T_W-1:0] t_q;
  logic [DT_W-1:0]       dt_q;
  logic [PROD_W-1:0]     prod_q;

  logic                  cfg_wr;
  ffs_reg_e              cfg_idx;
  logic                  in_fire;

  logic [FRAME_BITS-1:0] cnt;
  logic [FRAME_BITS-1:0] cnt_m1;
  logic [FRAME_BITS-1:0] ping_fwd;
  logic [FRAME_BITS-1:0] ping_bwd;
  logic [FRAME_BITS-1:0] start_pos;
  logic [TIME_W-1:0]     dur;

  logic signed [T_W-1:0] add_a;
  logic signed [T_W-1:0] add_b;
  logic signed [T_W-1:0] add_sum;

  logic                  at_end;
  logic [FRAME_BITS-1:0] step_frame;
  logic                  step_dir;
  logic [LOOP_W-1:0]     step_loops;
  logic                  step_stop;

  // Register port
  assign pready  = 1'b1;
  assign cfg_idx = ffs_reg_e'(paddr[APB_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q    <= FRAME_COUNT_RST;
      frame_duration_q <= FRAME_DURATION_RST;
      speed_q          <= SPEED_RST;
      loop_forever_q   <= 1'b0;
      ping_pong_q      <= 1'b0;
      loop_budget_q    <= '0;
      start_backward_q <= 1'b0;
      start_frame_q    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_COUNT:    frame_count_q    <= pwdata[FRAME_BITS-1:0];
        REG_FRAME_DURATION: frame_duration_q <= pwdata[TIME_W-1:0];
        REG_SPEED:          speed_q          <= pwdata[SPEED_W-1:0];
        REG_LOOP_FOREVER:   loop_forever_q   <= pwdata[0];
        REG_PING_PONG:      ping_pong_q      <= pwdata[0];
        REG_LOOP_BUDGET:    loop_budget_q    <= pwdata[LOOP_W-1:0];
        REG_START_BACKWARD: start_backward_q <= pwdata[0];
        REG_START_FRAME:    start_frame_q    <= pwdata[FRAME_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_COUNT:    prdata = APB_DW'(frame_count_q);
      REG_FRAME_DURATION: prdata = APB_DW'(frame_duration_q);
      REG_SPEED:          prdata = APB_DW'(speed_q);
      REG_LOOP_FOREVER:   prdata = APB_DW'(loop_forever_q);
      REG_PING_PONG:      prdata = APB_DW'(ping_pong_q);
      REG_LOOP_BUDGET:    prdata = APB_DW'(loop_budget_q);
      REG_START_BACKWARD: prdata = APB_DW'(start_backward_q);
      REG_START_FRAME:    prdata = APB_DW'(start_frame_q);
    endcase
  end

  // Frame range
  assign cnt       = (frame_count_q == '0) ? FRAME_BITS'(1) : frame_count_q;
  assign cnt_m1    = cnt - FRAME_BITS'(1);
  assign ping_fwd  = (cnt_m1 != '0) ? cnt_m1 - FRAME_BITS'(1) : '0;
  assign ping_bwd  = (cnt_m1 != '0) ? FRAME_BITS'(1) : '0;
  assign start_pos = (start_frame_q > cnt_m1) ? cnt_m1 : start_frame_q;
  assign dur       = (frame_duration_q == '0) ? TIME_W'(1) : frame_duration_q;

  // Shared adder: consume scaled time, then add one duration per step
  always_comb begin
    if (state_q == ST_STEP) begin
      add_a = t_q;
      add_b = $signed({{(T_W-TIME_W){1'b0}}, dur});
    end else begin
      add_a = $signed({{(T_W-TIME_W){1'b0}}, time_left_q});
      add_b = -$signed({{(T_W-SCL_W){1'b0}}, prod_q[PROD_W-1:SPEED_FRAC]});
    end
    add_sum = add_a + add_b;
  end

  // One frame step
  always_comb begin
    step_frame = frame_pos_q;
    step_dir   = dir_q;
    step_loops = loops_left_q;
    step_stop  = 1'b0;
    at_end     = dir_q ? (frame_pos_q == '0) : (frame_pos_q >= cnt_m1);
    if (!at_end) begin
      step_frame = dir_q ? frame_pos_q - FRAME_BITS'(1) : frame_pos_q + FRAME_BITS'(1);
    end else if (loop_forever_q || (loops_left_q != '0)) begin
      if (loops_left_q != '0) begin
        step_loops = loops_left_q - LOOP_W'(1);
      end
      if (ping_pong_q) begin
        step_dir   = !dir_q;
        step_frame = dir_q ? ping_bwd : ping_fwd;
      end else begin
        step_frame = dir_q ? cnt_m1 : '0;
      end
    end else begin
      step_stop  = 1'b1;
      step_frame = dir_q ? '0 : cnt_m1;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      frame_pos_q  <= '0;
      dir_q        <= 1'b0;
      loops_left_q <= '0;
      time_left_q  <= '0;
      ended_q      <= 1'b1;
      t_q          <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (op_i == OP_START) begin
              ended_q      <= 1'b0;
              frame_pos_q  <= start_pos;
              dir_q        <= start_backward_q;
              loops_left_q <= loop_budget_q;
              time_left_q  <= frame_duration_q;
              state_q      <= ST_OUT;
            end else if (ended_q) begin
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state_q <= ST_SUB;
        end
        ST_SUB: begin
          if (!add_sum[T_W-1]) begin
            time_left_q <= add_sum[TIME_W-1:0];
            state_q     <= ST_OUT;
          end else begin
            t_q     <= add_sum;
            state_q <= ST_STEP;
          end
        end
        ST_STEP: begin
          frame_pos_q  <= step_frame;
          dir_q        <= step_dir;
          loops_left_q <= step_loops;
          t_q          <= add_sum;
          if (step_stop) begin
            ended_q <= 1'b1;
            state_q <= ST_OUT;
          end else if (add_sum > 0) begin
            time_left_q <= add_sum[TIME_W-1:0];
            state_q     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dt_q <= dt_i;
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(dt_q) * PROD_W'(speed_q);
    end
  end

  assign out_valid_o   = (state_q == ST_OUT);
  assign frame_index_o = (frame_pos_q > cnt_m1) ? cnt_m1 : frame_pos_q;
  assign backward_o    = dir_q;
  assign stopped_o     = ended_q;

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result item is pending");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == OP_START)) |=> (out_valid_o && !stopped_o))
    else $error("start item did not restart playback");

  a_stopped_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (op_i == OP_TICK) && ended_q) |=>
      (out_valid_o && stopped_o && $stable(frame_pos_q)))
    else $error("tick changed a stopped animation");

  a_step_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |-> (t_q <= 0))
    else $error("frame step with time left above zero");

  a_loops_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP) |=> (loops_left_q <= $past(loops_left_q)))
    else $error("loop budget grew during a tick");

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for flipbook_frame_sequencer. Items go in through
// a valid/ready channel with random gaps. Registers are set over APB and read
// back. A built-in player model predicts frame, direction and stop flag for
// every item, and each result is checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb;
  import ffs_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int STEP_CAP    = 256;
  localparam int DEEP_CAP    = 4096;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 115;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_index;
    logic                  backward;
    logic                  stopped;
  } frame_view_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  op_i;
  logic [DT_W-1:0]       dt_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [FRAME_BITS-1:0] frame_index_o;
  logic                  backward_o;
  logic                  stopped_o;

  flipbook_frame_sequencer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .dt_i          (dt_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_index_o (frame_index_o),
    .backward_o    (backward_o),
    .stopped_o     (stopped_o)
  );

  // Register shadow
  logic [7:0]        cfg_count;
  logic [TIME_W-1:0] cfg_duration;
  logic [15:0]       cfg_speed;
  logic              cfg_endless;
  logic              cfg_bounce;
  logic [7:0]        cfg_budget;
  logic              cfg_start_bwd;
  logic [7:0]        cfg_start_frame;

  // Player state
  logic [8:0]        play_frame;
  logic              play_bwd;
  logic [LOOP_W-1:0] loops_left;
  logic [31:0]       time_left;
  logic              play_done;

  frame_view_t pending_views[$];
  frame_view_t want_view;

  int          errors;
  int          items_sent;
  int          starts_sent;
  int          results_seen;
  int          settings_used;
  int          turns;
  int          stops;
  int          hold_request;
  int unsigned cycle_count;
  logic        tx_idle;
  logic        rx_idle;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int eff_count();
    return (cfg_count < 8'd1) ? 1 : int'(cfg_count);
  endfunction

  function automatic int eff_duration();
    return (cfg_duration == '0) ? 1 : int'(cfg_duration);
  endfunction

  function automatic logic [8:0] clamp_frame(int f);
    int last;
    last = eff_count() - 1;
    if (f < 0) return 9'd0;
    if (f > last) return 9'(last);
    return 9'(f);
  endfunction

  function automatic bit turn_at_end(int bounce_target, int wrap_target);
    if (!(cfg_endless || loops_left != '0)) return 1'b0;
    if (loops_left != '0) loops_left--;
    turns++;
    if (cfg_bounce) begin
      play_bwd   = !play_bwd;
      play_frame = clamp_frame(bounce_target);
    end else begin
      play_frame = clamp_frame(wrap_target);
    end
    return 1'b1;
  endfunction

  function automatic void play_tick(logic [DT_W-1:0] dt);
    longint t;
    longint dur;
    int     cnt;
    int     f;
    dur = longint'(eff_duration());
    cnt = eff_count();
    t   = longint'(time_left) - ((longint'(dt) * longint'(cfg_speed)) >> SPEED_FRAC);
    if (t >= 0) begin
      time_left = 32'(t);
      return;
    end
    do begin
      t += dur;
      if (play_bwd) begin
        f = int'(play_frame) - 1;
        if (f < 0) begin
          if (!turn_at_end(1, cnt - 1)) begin
            play_done  = 1'b1;
            stops++;
            play_frame = clamp_frame(f);
            return;
          end
        end else begin
          play_frame = 9'(f);
        end
      end else begin
        f = int'(play_frame) + 1;
        if (f >= cnt) begin
          if (!turn_at_end(cnt - 2, 0)) begin
            play_done  = 1'b1;
            stops++;
            play_frame = clamp_frame(f);
            return;
          end
        end else begin
          play_frame = 9'(f);
        end
      end
    end while (t <= 0);
    time_left = 32'(t);
  endfunction

  function automatic void play_item(logic op, logic [DT_W-1:0] dt);
    if (op == OP_START) begin
      play_done  = 1'b0;
      play_frame = clamp_frame(int'(cfg_start_frame));
      play_bwd   = cfg_start_bwd;
      loops_left = cfg_budget;
      time_left  = 32'(cfg_duration);
    end else if (!play_done) begin
      play_tick(dt);
    end
  endfunction

  function automatic frame_view_t current_view();
    frame_view_t v;
    logic [8:0]  shown;
    shown         = clamp_frame(int'(play_frame));
    v.frame_index = shown[FRAME_BITS-1:0];
    v.backward    = play_bwd;
    v.stopped     = play_done;
    return v;
  endfunction

  function automatic void reset_player();
    cfg_count       = FRAME_COUNT_RST;
    cfg_duration    = FRAME_DURATION_RST;
    cfg_speed       = SPEED_RST;
    cfg_endless     = 1'b0;
    cfg_bounce      = 1'b0;
    cfg_budget      = '0;
    cfg_start_bwd   = 1'b0;
    cfg_start_frame = '0;
    play_frame      = '0;
    play_bwd        = 1'b0;
    loops_left      = '0;
    time_left       = '0;
    play_done       = 1'b1;
  endfunction

  // Limit a tick so that it takes at most cap + 1 frame steps.
  function automatic logic [DT_W-1:0] bounded_dt(logic [DT_W-1:0] dt, int cap);
    longint budget;
    longint max_dt;
    if (play_done || cfg_speed == '0) return dt;
    budget = longint'(time_left) + longint'(eff_duration()) * cap;
    if (((longint'(dt) * longint'(cfg_speed)) >> SPEED_FRAC) <= budget) return dt;
    max_dt = ((budget + 1) * 4096 - 1) / longint'(cfg_speed);
    if (max_dt > 65535) max_dt = 65535;
    return DT_W'($urandom_range(0, int'(max_dt)));
  endfunction

  function automatic logic [DT_W-1:0] pace_dt();
    longint span;
    case ($urandom_range(0, 3))
      0: return DT_W'($urandom_range(0, 255));
      1: return DT_W'($urandom);
      default: begin
        span = (longint'(eff_duration()) * 3 * 4096) /
               ((cfg_speed == '0) ? 1 : longint'(cfg_speed));
        if (span > 65535) span = 65535;
        return DT_W'($urandom_range(0, int'(span)));
      end
    endcase
  endfunction

  function automatic logic [APB_DW-1:0] reg_mask(ffs_reg_e idx);
    case (idx)
      REG_FRAME_COUNT, REG_LOOP_BUDGET, REG_START_FRAME: return 32'hFF;
      REG_FRAME_DURATION: return 32'hFF_FFFF;
      REG_SPEED: return 32'hFFFF;
      default: return 32'h1;
    endcase
  endfunction

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input ffs_reg_e idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] readback;
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_FRAME_COUNT:    cfg_count       = value[7:0];
      REG_FRAME_DURATION: cfg_duration    = value[TIME_W-1:0];
      REG_SPEED:          cfg_speed       = value[15:0];
      REG_LOOP_FOREVER:   cfg_endless     = value[0];
      REG_PING_PONG:      cfg_bounce      = value[0];
      REG_LOOP_BUDGET:    cfg_budget      = value[7:0];
      REG_START_BACKWARD: cfg_start_bwd   = value[0];
      default:            cfg_start_frame = value[7:0];
    endcase
    if (readback !== (value & reg_mask(idx))) begin
      $error("register %s: expected %0h, got %0h", idx.name(), value & reg_mask(idx),
             readback);
      errors++;
    end
  endtask

  task automatic configure(input logic [7:0] count, input logic [TIME_W-1:0] dur,
                           input logic [15:0] spd, input logic endless,
                           input logic bounce, input logic [7:0] budget,
                           input logic bwd, input logic [7:0] first);
    write_reg(REG_FRAME_COUNT, 32'(count));
    write_reg(REG_FRAME_DURATION, 32'(dur));
    write_reg(REG_SPEED, 32'(spd));
    write_reg(REG_LOOP_FOREVER, 32'(endless));
    write_reg(REG_PING_PONG, 32'(bounce));
    write_reg(REG_LOOP_BUDGET, 32'(budget));
    write_reg(REG_START_BACKWARD, 32'(bwd));
    write_reg(REG_START_FRAME, 32'(first));
    settings_used++;
  endtask

  task automatic send_item(input logic op, input logic [DT_W-1:0] dt, input int cap);
    int              gap;
    logic [DT_W-1:0] d;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    d = (op == OP_TICK) ? bounded_dt(dt, cap) : dt;
    in_valid_i <= 1'b1;
    op_i       <= op;
    dt_i       <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    play_item(op, d);
    pending_views.push_back(current_view());
    items_sent++;
    if (op == OP_START) starts_sent++;
  endtask

  task automatic test_stopped_after_reset();
    send_item(OP_TICK, 16'h0000, STEP_CAP);
    send_item(OP_TICK, 16'hFFFF, STEP_CAP);
    send_item(OP_START, 16'h0000, STEP_CAP);
    send_item(OP_TICK, 16'd1, STEP_CAP);
    send_item(OP_TICK, 16'd1, STEP_CAP);
  endtask

  task automatic test_wrap_budget();
    configure(8'd5, 24'd100, 16'd4096, 1'b0, 1'b0, 8'd2, 1'b0, 8'd3);
    send_item(OP_START, 16'hFFFF, STEP_CAP);
    send_item(OP_TICK, 16'd150, STEP_CAP);
    send_item(OP_TICK, 16'd250, STEP_CAP);
    send_item(OP_TICK, 16'd1000, STEP_CAP);
    send_item(OP_TICK, 16'd7, STEP_CAP);
  endtask

  task automatic test_ping_pong();
    configure(8'd4, 24'd64, 16'd8192, 1'b1, 1'b1, 8'd0, 1'b1, 8'd2);
    send_item(OP_START, 16'h0000, STEP_CAP);
    send_item(OP_TICK, 16'd40, STEP_CAP);
    send_item(OP_TICK, 16'd200, STEP_CAP);
    configure(8'd3, 24'd10, 16'd4096, 1'b0, 1'b1, 8'd1, 1'b0, 8'd0);
    send_item(OP_START, 16'h0000, STEP_CAP);
    send_item(OP_TICK, 16'd100, STEP_CAP);
  endtask

  task automatic test_degenerate_sizes();
    configure(8'd0, 24'd0, 16'd4096, 1'b1, 1'b1, 8'd0, 1'b0, 8'd5);
    send_item(OP_START, 16'h0000, STEP_CAP);
    send_item(OP_TICK, 16'd3, STEP_CAP);
    configure(8'd1, 24'd0, 16'd4096, 1'b1, 1'b0, 8'd0, 1'b1, 8'd0);
    send_item(OP_START, 16'h0000, STEP_CAP);
    send_item(OP_TICK, 16'd3, STEP_CAP);
  endtask

  task automatic test_extreme_values();
    configure(8'd255, 24'hFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 8'd255, 1'b1, 8'd255);
    send_item(OP_START, 16'hFFFF, STEP_CAP);
    send_item(OP_TICK, 16'hFFFF, STEP_CAP);
    write_reg(REG_SPEED, 32'd0);
    send_item(OP_TICK, 16'hFFFF, STEP_CAP);
  endtask

  task automatic test_frame_beyond_count();
    configure(8'd255, 24'd10, 16'd4096, 1'b1, 1'b0, 8'd0, 1'b0, 8'd200);
    send_item(OP_START, 16'h0000, STEP_CAP);
    send_item(OP_TICK, 16'd5, STEP_CAP);
    write_reg(REG_FRAME_COUNT, 32'd50);
    send_item(OP_TICK, 16'd4, STEP_CAP);
    send_item(OP_TICK, 16'd20, STEP_CAP);
  endtask

  task automatic test_backpressure();
    configure(8'd6, 24'd50, 16'd4096, 1'b1, 1'b1, 8'd0, 1'b0, 8'd0);
    hold_request = HOLD_CYCLES;
    send_item(OP_START, 16'h0000, STEP_CAP);
    repeat (15) send_item(OP_TICK, pace_dt(), STEP_CAP);
  endtask

  task automatic pick_settings(input int phase);
    logic [7:0]        count;
    logic [7:0]        budget;
    logic [TIME_W-1:0] dur;
    logic [15:0]       spd;
    case (phase)
      0: configure(8'd2, 24'd1, 16'd1, 1'b0, 1'b0, 8'd0, 1'b0, 8'd0);
      1: configure(8'd255, 24'hFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 8'd255, 1'b1, 8'd255);
      default: begin
        case ($urandom_range(0, 5))
          0:       count = 8'd0;
          1:       count = 8'd1;
          2:       count = 8'd255;
          3, 4:    count = 8'($urandom_range(2, 16));
          default: count = 8'($urandom_range(2, 255));
        endcase
        case ($urandom_range(0, 5))
          0:       dur = TIME_W'($urandom_range(0, 1));
          1, 2:    dur = TIME_W'($urandom_range(2, 16));
          3:       dur = TIME_W'($urandom_range(17, 4095));
          4:       dur = TIME_W'($urandom_range(4096, 24'hFF_FFFF));
          default: dur = 24'hFF_FFFF;
        endcase
        case ($urandom_range(0, 4))
          0:       spd = 16'($urandom_range(0, 4095));
          1:       spd = 16'd4096;
          2:       spd = 16'hFFFF;
          3:       spd = 16'($urandom);
          default: spd = 16'($urandom_range(2048, 12288));
        endcase
        case ($urandom_range(0, 4))
          0:       budget = 8'd0;
          1:       budget = 8'd255;
          2, 3:    budget = 8'($urandom_range(0, 8));
          default: budget = 8'($urandom);
        endcase
        configure(count, dur, spd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  budget, 1'($urandom_range(0, 1)), 8'($urandom));
      end
    endcase
  endtask

  task automatic test_random_play();
    int              counted;
    logic            op;
    logic            deep;
    logic [DT_W-1:0] dt;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      pick_settings(phase);
      send_item(OP_START, DT_W'($urandom), STEP_CAP);
      counted = 1;
      while (counted < PHASE_ITEMS) begin
        if (play_done) op = ($urandom_range(0, 1) == 0) ? OP_START : OP_TICK;
        else op = ($urandom_range(0, 15) == 0) ? OP_START : OP_TICK;
        deep = ($urandom_range(0, 99) == 0);
        dt   = deep ? DT_W'($urandom) : pace_dt();
        if (op == OP_START || !play_done) counted++;
        send_item(op, dt, deep ? DEEP_CAP : STEP_CAP);
      end
    end
  endtask

  initial begin : result_sink
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      gap = rx_idle ? $urandom_range(0, 9) : 0;
      if (hold_request > 0) begin
        gap          = hold_request;
        hold_request = 0;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_views.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want_view = pending_views.pop_front();
        if (frame_index_o !== want_view.frame_index) begin
          $error("frame_index: expected %0d, got %0d", want_view.frame_index, frame_index_o);
          errors++;
        end
        if (backward_o !== want_view.backward) begin
          $error("backward: expected %0d, got %0d", want_view.backward, backward_o);
          errors++;
        end
        if (stopped_o !== want_view.stopped) begin
          $error("stopped: expected %0d, got %0d", want_view.stopped, stopped_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_views.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_valid_i    = 1'b0;
    op_i          = OP_TICK;
    dt_i          = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;
    cycle_count   = 0;
    errors        = 0;
    items_sent    = 0;
    starts_sent   = 0;
    results_seen  = 0;
    settings_used = 0;
    turns         = 0;
    stops         = 0;
    hold_request  = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    reset_player();
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_stopped_after_reset();
    test_wrap_budget();
    test_ping_pong();
    test_degenerate_sizes();
    test_extreme_values();
    test_frame_beyond_count();
    test_backpressure();
    test_random_play();

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d items (%0d starts) under %0d register settings, checked %0d results.",
             items_sent, starts_sent, settings_used, results_seen);
    $display("Model saw %0d wraps or reversals and %0d stops, with stalls on both sides.",
             turns, stops);
    if (errors == 0 && pending_views.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ffs_pkg.sv
rtl/flipbook_frame_sequencer.sv
verif/tb.sv
